// ===== sv/lmsp_pkg.sv =====
`default_nettype none

package lmsp_pkg;

   // Matrix geometry and PWM depth.
   localparam int COLUMNS      = 48;
   localparam int ROWS         = 12;
   localparam int BRIGHT_SLOTS = 8;

   // Derived sizes.
   localparam int GROUPS  = COLUMNS / 2;
   localparam int GROUP_W = $clog2(GROUPS);
   localparam int SLOT_W  = $clog2(BRIGHT_SLOTS);
   localparam int MEM_AW  = $clog2(2 * GROUPS);

   // Fixed field widths of the item channels.
   localparam int COL_IDX_W   = 6;
   localparam int COL_BITS_W  = 12;
   localparam int GROUP_IDX_W = 5;
   localparam int OUT_ROWS_W  = 12;

   // Control and status register port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;
   localparam int BRIGHT_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_OFF = 1'd1;

   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd3;

   // Item action codes.
   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // Memory access request from the scan control to the frame store.
   typedef struct packed {
      logic              rd_en;
      logic [MEM_AW-1:0] rd_addr;
      logic              wr_even;
      logic              wr_odd;
      logic [MEM_AW-1:0] wr_addr;
      logic [ROWS-1:0]   wr_data;
   } lmsp_mem_req_type;

   // Tick information that travels alongside the frame store read.
   typedef struct packed {
      logic [GROUP_IDX_W-1:0] group_index;
      logic                   lit;
      logic                   frame_start;
   } lmsp_meta_type;

endpackage

`default_nettype wire

// ===== sv/lmsp_if.sv =====
`default_nettype none

// Input item channel.
interface lmsp_req_if import lmsp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [COL_IDX_W-1:0]  column_index;
   logic [COL_BITS_W-1:0] column_bits;

   modport source (output valid, output action, output column_index,
                   output column_bits, input ready);
   modport sink   (input valid, input action, input column_index,
                   input column_bits, output ready);
endinterface

// Result item channel.
interface lmsp_rsp_if import lmsp_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [GROUP_IDX_W-1:0] group_index;
   logic [OUT_ROWS_W-1:0]  even_column_rows;
   logic [OUT_ROWS_W-1:0]  odd_column_rows;
   logic                   lit;
   logic                   frame_start;

   modport source (output valid, output group_index, output even_column_rows,
                   output odd_column_rows, output lit, output frame_start,
                   input ready);
   modport sink   (input valid, input group_index, input even_column_rows,
                   input odd_column_rows, input lit, input frame_start,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/led_matrix_scan_pwm.sv =====
`default_nettype none

// A tick item's result passes through the frame store output register and then the result register.
// Throughput: one item per cycle while rsp.ready keeps the result stage moving; a write item gives no result.
// The frame store is read in the cycle of acceptance and its output register
// holds the pair while the result register waits on rsp.ready.
// Reset clears counters, bank select and the frame store written flags at
// once; there is no clearing pass, items are accepted right after reset.
module led_matrix_scan_pwm import lmsp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   lmsp_req_if.sink                   req,
   lmsp_rsp_if.source                 rsp
);

   lmsp_mem_req_type mem_req;
   lmsp_meta_type    meta;
   logic [ROWS-1:0]  even_rows;
   logic [ROWS-1:0]  odd_rows;

   logic             accept;
   logic             tick_en;
   logic             write_en;
   logic             out_adv;
   logic             s1_adv;

   logic             s1_vld_ff;
   logic             s1_vld_in;
   lmsp_meta_type    s1_meta_ff;

   logic             out_vld_ff;
   logic             out_vld_in;
   lmsp_meta_type    out_meta_ff;
   logic [OUT_ROWS_W-1:0] out_even_ff;
   logic [OUT_ROWS_W-1:0] out_odd_ff;

   // Handshake and pipeline advance.
   assign out_adv   = !out_vld_ff || rsp.ready;
   assign s1_adv    = s1_vld_ff && out_adv;
   assign req.ready = !s1_vld_ff || out_adv;
   assign accept    = req.valid && req.ready;
   assign tick_en   = accept && (req.action == ACT_TICK);
   assign write_en  = accept && (req.action == ACT_WRITE);

   lmsp_scan_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .tick_en      (tick_en),
      .write_en     (write_en),
      .column_index (req.column_index),
      .column_bits  (req.column_bits),
      .mem_req      (mem_req),
      .meta         (meta)
   );

   lmsp_frame_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .even_rows (even_rows),
      .odd_rows  (odd_rows)
   );

   // Read stage: tick status waits here beside the memory output register.
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (tick_en) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
   end

   // Result stage.
   always_comb begin
      out_vld_in = out_vld_ff;
      if (s1_adv) begin
         out_vld_in = 1'b1;
      end else if (rsp.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_en) begin
         s1_meta_ff <= meta;
      end
      if (s1_adv) begin
         out_meta_ff <= s1_meta_ff;
         out_even_ff <= s1_meta_ff.lit ? OUT_ROWS_W'(even_rows) : '0;
         out_odd_ff  <= s1_meta_ff.lit ? OUT_ROWS_W'(odd_rows) : '0;
      end
   end

   assign rsp.valid            = out_vld_ff;
   assign rsp.group_index      = out_meta_ff.group_index;
   assign rsp.even_column_rows = out_even_ff;
   assign rsp.odd_column_rows  = out_odd_ff;
   assign rsp.lit              = out_meta_ff.lit;
   assign rsp.frame_start      = out_meta_ff.frame_start;

endmodule

`default_nettype wire

// ===== sv/lmsp_frame_mem.sv =====
`default_nettype none

// Frame store: even and odd columns in two memories addressed by
// bank * GROUPS + group, so one read returns a whole column pair.
module lmsp_frame_mem import lmsp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lmsp_mem_req_type mem_req,
   output logic [ROWS-1:0]       even_rows,
   output logic [ROWS-1:0]       odd_rows
);

   localparam int DEPTH = 2 * GROUPS;

   logic [ROWS-1:0] even_mem [DEPTH];
   logic [ROWS-1:0] odd_mem  [DEPTH];

   logic [DEPTH-1:0] even_vld_ff;
   logic [DEPTH-1:0] odd_vld_ff;

   logic [ROWS-1:0] even_data_ff;
   logic [ROWS-1:0] odd_data_ff;
   logic            even_hit_ff;
   logic            odd_hit_ff;

   // Memory writes and registered reads.
   always_ff @(posedge clock) begin
      if (mem_req.wr_even) begin
         even_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.wr_odd) begin
         odd_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         even_data_ff <= even_mem[mem_req.rd_addr];
         odd_data_ff  <= odd_mem[mem_req.rd_addr];
      end
   end

   // Written flags; an entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         even_vld_ff <= '0;
         odd_vld_ff  <= '0;
         even_hit_ff <= 1'b0;
         odd_hit_ff  <= 1'b0;
      end else begin
         if (mem_req.wr_even) begin
            even_vld_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.wr_odd) begin
            odd_vld_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            even_hit_ff <= even_vld_ff[mem_req.rd_addr];
            odd_hit_ff  <= odd_vld_ff[mem_req.rd_addr];
         end
      end
   end

   assign even_rows = even_hit_ff ? even_data_ff : '0;
   assign odd_rows  = odd_hit_ff ? odd_data_ff : '0;

endmodule

`default_nettype wire

// ===== sv/lmsp_scan_ctrl.sv =====
`default_nettype none

// Scan control: configuration registers, group and slot counters, frame
// bank selection, and the memory requests for ticks and column writes.
module lmsp_scan_ctrl import lmsp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  tick_en,
   input  wire logic                  write_en,
   input  wire logic [COL_IDX_W-1:0]  column_index,
   input  wire logic [COL_BITS_W-1:0] column_bits,
   output lmsp_mem_req_type           mem_req,
   output lmsp_meta_type              meta
);

   logic [BRIGHT_W-1:0] brightness_ff;
   logic                display_off_ff;
   logic                front_ff;
   logic [GROUP_W-1:0]  group_ff;
   logic [SLOT_W-1:0]   slot_ff;

   logic                front_in;
   logic [GROUP_W-1:0]  group_in;
   logic [SLOT_W-1:0]   slot_in;

   logic                on;
   logic                col_ok;
   logic [GROUP_W-1:0]  wr_group;

   function automatic logic [MEM_AW-1:0] frame_addr(input logic bank,
                                                    input logic [GROUP_W-1:0] grp);
      return bank ? MEM_AW'(GROUPS) + MEM_AW'(grp) : MEM_AW'(grp);
   endfunction

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff  <= BRIGHT_RESET;
         display_off_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BRIGHTNESS:  brightness_ff  <= BRIGHT_W'(csr_wdata);
            CSR_DISPLAY_OFF: display_off_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign on = !display_off_ff;

   // Counter advance: group, then slot on group wrap, then bank on slot wrap.
   always_comb begin
      front_in = front_ff;
      group_in = group_ff;
      slot_in  = slot_ff;
      if (tick_en && on) begin
         if (group_ff == GROUP_W'(GROUPS - 1)) begin
            group_in = '0;
            if (slot_ff == SLOT_W'(BRIGHT_SLOTS - 1)) begin
               slot_in  = '0;
               front_in = !front_ff;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end else begin
            group_in = group_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= 1'b0;
         group_ff <= '0;
         slot_ff  <= '0;
      end else begin
         front_ff <= front_in;
         group_ff <= group_in;
         slot_ff  <= slot_in;
      end
   end

   // Tick status, taken from the counters before they advance.
   assign meta.group_index = GROUP_IDX_W'(group_ff);
   assign meta.lit         = on && (32'(slot_ff) <= 32'(brightness_ff));
   assign meta.frame_start = on && (group_ff == '0) && (slot_ff == '0);

   // Column writes go to the back bank; out-of-range columns are dropped.
   assign col_ok   = 32'(column_index) < COLUMNS;
   assign wr_group = GROUP_W'(column_index >> 1);

   assign mem_req.rd_en   = tick_en;
   assign mem_req.rd_addr = frame_addr(front_ff, group_ff);
   assign mem_req.wr_even = write_en && col_ok && !column_index[0];
   assign mem_req.wr_odd  = write_en && col_ok && column_index[0];
   assign mem_req.wr_addr = frame_addr(!front_ff, wr_group);
   assign mem_req.wr_data = ROWS'(column_bits);

endmodule

`default_nettype wire

// ===== sim/tb_led_matrix_scan_pwm.sv =====
`timescale 1ns / 100ps

module tb_led_matrix_scan_pwm;
   import lmsp_pkg::*;

   localparam int RANDOM_ITEMS = 1350;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 4;

   // One input item as the driver offers it.
   typedef struct packed {
      logic                  action;
      logic [COL_IDX_W-1:0]  column_index;
      logic [COL_BITS_W-1:0] column_bits;
   } scan_req_type;

   // One predicted scan result.
   typedef struct packed {
      logic [GROUP_IDX_W-1:0] group_index;
      logic [OUT_ROWS_W-1:0]  even_column_rows;
      logic [OUT_ROWS_W-1:0]  odd_column_rows;
      logic                   lit;
      logic                   frame_start;
   } scan_out_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lmsp_req_if req_ch ();
   lmsp_rsp_if rsp_ch ();

   led_matrix_scan_pwm u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   // Stimulus and expectation stores.
   scan_req_type pending_items [$];
   scan_out_type scan_results [$];

   int  error_count    = 0;
   int  cycle_count    = 0;
   int  accepted_items = 0;
   int  stim_count     = 0;
   int  send_gap;
   int  ready_gap;
   int  hold_left;
   int  next_hold_at;
   bit  idle_enable;

   // Shadow copy of the display state: both frame banks, scan counters and registers.
   logic [ROWS-1:0]     frame_mem [0:2*COLUMNS-1];
   logic                front_bank;
   int                  scan_grp;
   int                  pwm_slot;
   logic [BRIGHT_W-1:0] bright_reg;
   logic                panel_off;

   // Clock generation.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Gap length: mostly none, sometimes short, rarely long.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // Apply one accepted item to the shadow state and queue the scan result it gives.
   function automatic void predict_item(input logic act, input logic [COL_IDX_W-1:0] col,
                                        input logic [COL_BITS_W-1:0] bits);
      scan_out_type res;
      int           base;
      logic         shown;
      if (act == ACT_WRITE) begin
         // Writes land in the back bank; columns past the matrix are dropped.
         if (col < COLUMNS) begin
            base = front_bank ? 0 : COLUMNS;
            frame_mem[base + col] = bits[ROWS-1:0];
         end
         return;
      end
      base = front_bank ? COLUMNS : 0;
      shown = !panel_off && (pwm_slot <= bright_reg);
      res.group_index      = scan_grp[GROUP_IDX_W-1:0];
      res.even_column_rows = shown ? OUT_ROWS_W'(frame_mem[base + 2 * scan_grp]) : '0;
      res.odd_column_rows  = shown ? OUT_ROWS_W'(frame_mem[base + 2 * scan_grp + 1]) : '0;
      res.lit              = shown;
      res.frame_start      = !panel_off && scan_grp == 0 && pwm_slot == 0;
      scan_results.push_back(res);
      // Counters freeze while the display is off.
      if (!panel_off) begin
         scan_grp++;
         if (scan_grp >= GROUPS) begin
            scan_grp = 0;
            pwm_slot++;
            if (pwm_slot >= BRIGHT_SLOTS) begin
               pwm_slot   = 0;
               front_bank = ~front_bank;
            end
         end
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Driver: offers queued items and updates the prediction at each accepted item.
   always @(posedge clock) begin : driver
      scan_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_item(req_ch.action, req_ch.column_index, req_ch.column_bits);
            accepted_items <= accepted_items + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               req_ch.valid <= 1'b0;
               send_gap     <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
               nxt = pending_items.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.action       <= nxt.action;
               req_ch.column_index <= nxt.column_index;
               req_ch.column_bits  <= nxt.column_bits;
               send_gap            <= idle_enable ? draw_gap() : 0;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off while the sender still has plenty queued.
   always @(posedge clock) begin
      if (reset) begin
         hold_left    <= 0;
         next_hold_at <= 300;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (accepted_items >= next_hold_at && pending_items.size() > 40) begin
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + 600;
      end
   end

   // Monitor: checks each accepted result item and paces rsp ready.
   always @(posedge clock) begin : monitor
      scan_out_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_gap    <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (scan_results.size() == 0) begin
               $error("unexpected result item: group_index %0d", rsp_ch.group_index);
               error_count++;
            end else begin
               want = scan_results.pop_front();
               check_field("group_index", want.group_index, rsp_ch.group_index);
               check_field("even_column_rows", want.even_column_rows, rsp_ch.even_column_rows);
               check_field("odd_column_rows", want.odd_column_rows, rsp_ch.odd_column_rows);
               check_field("lit", want.lit, rsp_ch.lit);
               check_field("frame_start", want.frame_start, rsp_ch.frame_start);
            end
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (ready_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            ready_gap    <= ready_gap - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_ch.ready && idle_enable) ready_gap <= draw_gap();
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic add_write(input int col, input logic [COL_BITS_W-1:0] bits);
      pending_items.push_back('{ACT_WRITE, COL_IDX_W'(col), bits});
      if (col < COLUMNS) stim_count++;
   endtask

   task automatic add_tick();
      pending_items.push_back('{ACT_TICK, COL_IDX_W'($urandom_range(0, 63)),
                                COL_BITS_W'($urandom)});
      stim_count++;
   endtask

   // Register write; the shadow copy follows once the block has taken it.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BRIGHTNESS) bright_reg = val[BRIGHT_W-1:0];
      else panel_off = val[0];
   endtask

   // Wait until every item is sent and every result is back, then let the pipe settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_ch.valid || scan_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A well-formed sequence: load part or all of the back frame, then scan.
   task automatic queue_frame_burst();
      if ($urandom_range(0, 1) == 1) begin
         for (int c = 0; c < COLUMNS; c++) add_write(c, COL_BITS_W'($urandom));
      end else begin
         repeat ($urandom_range(1, 20))
            add_write($urandom_range(0, COLUMNS - 1), COL_BITS_W'($urandom));
      end
      repeat ($urandom_range(GROUPS, 200)) add_tick();
   endtask

   // Loose mix of ticks and writes, some aimed past the last column.
   task automatic queue_noise(input int n);
      repeat (n) begin
         if ($urandom_range(0, 1) == 1) add_tick();
         else if ($urandom_range(0, 3) == 0)
            add_write($urandom_range(COLUMNS, 63), COL_BITS_W'($urandom));
         else add_write($urandom_range(0, COLUMNS - 1), COL_BITS_W'($urandom));
      end
   endtask

   initial begin : stimulus
      int phase;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_BRIGHTNESS;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_TICK;
      req_ch.column_index = '0;
      req_ch.column_bits  = '0;
      rsp_ch.ready        = 1'b0;
      idle_enable         = 1'b1;
      for (int i = 0; i < 2 * COLUMNS; i++) frame_mem[i] = '0;
      front_bank = 1'b0;
      scan_grp   = 0;
      pwm_slot   = 0;
      bright_reg = BRIGHT_RESET;
      panel_off  = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: edge columns, full and empty rows, writes past the matrix,
      // first ticks after reset with frame start.
      add_write(0, 12'hFFF);
      add_write(1, 12'h000);
      add_write(46, 12'h5A5);
      add_write(47, 12'hA5A);
      add_write(48, 12'hFFF);
      add_write(63, 12'h800);
      repeat (4) add_tick();
      wait_drained();

      // Display off: blank results with held group, writes still stored.
      write_reg(CSR_DISPLAY_OFF, 3'b001);
      repeat (3) add_tick();
      add_write(2, 12'h3C3);
      add_tick();
      wait_drained();
      // Upper data bits are ignored by the one-bit register.
      write_reg(CSR_DISPLAY_OFF, 3'b110);
      repeat (2) add_tick();
      wait_drained();

      // Brightness extremes.
      write_reg(CSR_BRIGHTNESS, 3'd7);
      repeat (2) add_tick();
      wait_drained();
      write_reg(CSR_BRIGHTNESS, 3'd0);
      repeat (2) add_tick();
      wait_drained();

      // Random part: a fresh setting per phase, mostly well-formed frame sequences.
      stim_count = 0;
      phase      = 0;
      while (stim_count < RANDOM_ITEMS) begin
         if (phase == 0) write_reg(CSR_BRIGHTNESS, 3'd7);
         else if (phase == 1) write_reg(CSR_BRIGHTNESS, 3'd0);
         else write_reg(CSR_BRIGHTNESS, CSR_DATA_W'($urandom_range(0, 7)));
         if (phase == 2 || $urandom_range(0, 3) == 0) begin
            write_reg(CSR_DISPLAY_OFF, {2'($urandom_range(0, 3)), 1'b1});
            queue_noise($urandom_range(10, 25));
            wait_drained();
            write_reg(CSR_DISPLAY_OFF, {2'($urandom_range(0, 3)), 1'b0});
         end
         idle_enable = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 9) < 7) queue_frame_burst();
            else queue_noise($urandom_range(20, 60));
         end
         wait_drained();
         phase++;
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== led_matrix_scan_pwm.f =====
sv/lmsp_pkg.sv
sv/lmsp_if.sv
sv/lmsp_frame_mem.sv
sv/lmsp_scan_ctrl.sv
sv/led_matrix_scan_pwm.sv
sim/tb_led_matrix_scan_pwm.sv
